// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

// next-cycle implication that also holds through reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== hdl/ses_pkg.sv =====
package ses_pkg;

    // field widths
    localparam int MODE_W   = 2;
    localparam int SW_W     = 2;
    localparam int PWM_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int HOLD_W   = 9;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IDLE_PWM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_PWM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_PER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT  = 3'd4;

    // register reset values
    localparam logic [PWM_W-1:0]  RST_IDLE_PWM = 16'd1000;
    localparam logic [PWM_W-1:0]  RST_RUN_PWM  = 16'd1200;
    localparam logic [BYTE_W-1:0] RST_FIRE_PER = 8'd20;
    localparam logic [BYTE_W-1:0] RST_HOLD_LIM = 8'd40;
    localparam logic [BYTE_W-1:0] RST_LOCKOUT  = 8'd200;

    // remote modes and switch positions
    localparam logic [MODE_W-1:0] MODE_PREPARE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOTE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEYBRD  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STANDBY = 2'd3;
    localparam logic [SW_W-1:0]   SW_UP        = 2'd1;
    localparam logic [SW_W-1:0]   SW_DOWN      = 2'd2;
    localparam logic [SW_W-1:0]   SW_MID       = 2'd3;

    // counter limits
    localparam logic [HOLD_W-1:0] HOLD_MAX = 9'd511;
    localparam logic [BYTE_W-1:0] FIRE_MAX = 8'd255;
    localparam logic [HOLD_W-1:0] FIRE_GAP = 9'd5;

    // one result item
    typedef struct packed {
        logic             wheel_on;
        logic             trigger_on;
        logic             laser_en;
        logic [PWM_W-1:0] wheel_pwm;
    } t_result;

endpackage

// ===== hdl/shooter_enable_sequencer.sv =====
// channel  direction  width  contents
// s_axis   in         8      tick: mode, switch, right and left button
// m_axis   out        24     wheel pwm, laser, trigger, wheel state
// cfg      in         3+16   register index and write data
//
// one tick is accepted every cycle while the skid slot is empty; its result
// is registered. the update of all counters and the wheel flag is one
// combinational pass from the state registers to the output register.
// a skid register holds a second result when the master side stalls, so an
// input transaction is refused only when both result slots are full.
// reset is synchronous and restores register defaults and cleared state.
module shooter_enable_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] remote_mode, [3:2] mode_switch, [4] right_button, [5] left_button
    input  logic [ses_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] wheel_pwm, [16] laser_en, [17] trigger_on, [18] wheel_on
    output logic [ses_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ses_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ses_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ses_pkg::*;

    // configuration registers
    logic [PWM_W-1:0]  r_idle_pwm, r_run_pwm;
    logic [BYTE_W-1:0] r_fire_per, r_hold_lim, r_lockout;

    // block state
    logic              r_wheel, n_wheel;
    logic [SW_W-1:0]   r_last_sw, n_last_sw;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic [BYTE_W-1:0] r_lock, n_lock;
    logic [BYTE_W-1:0] r_fire, n_fire;

    // result slots
    t_result r_out, r_skid, n_res;
    logic    r_out_valid, r_skid_valid;

    logic [MODE_W-1:0] in_mode;
    logic [SW_W-1:0]   in_sw;
    logic              in_right, in_left;
    logic              accept, take;
    logic              stop_mode, sw_edge, hold_over, trig;
    logic [BYTE_W-1:0] lock_mid, fire_cnt;

    assign in_mode  = s_axis_tdata[1:0];
    assign in_sw    = s_axis_tdata[3:2];
    assign in_right = s_axis_tdata[4];
    assign in_left  = s_axis_tdata[5];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, r_out};

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_pwm <= RST_IDLE_PWM;
            r_run_pwm  <= RST_RUN_PWM;
            r_fire_per <= RST_FIRE_PER;
            r_hold_lim <= RST_HOLD_LIM;
            r_lockout  <= RST_LOCKOUT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IDLE_PWM: r_idle_pwm <= i_cfg_data;
                REG_RUN_PWM:  r_run_pwm  <= i_cfg_data;
                REG_FIRE_PER: r_fire_per <= i_cfg_data[BYTE_W-1:0];
                REG_HOLD_LIM: r_hold_lim <= i_cfg_data[BYTE_W-1:0];
                REG_LOCKOUT:  r_lockout  <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // one tick of the wheel and trigger sequencing
    always_comb begin
        stop_mode = (in_mode == MODE_PREPARE) || (in_mode == MODE_STANDBY);
        sw_edge   = (in_sw == SW_MID) && (r_last_sw == SW_UP);
        n_wheel   = r_wheel;
        n_last_sw = r_last_sw;
        n_hold    = r_hold;
        n_lock    = r_lock;
        n_fire    = r_fire;
        lock_mid  = r_lock;
        fire_cnt  = r_fire;
        hold_over = 1'b0;
        trig      = 1'b0;

        if (stop_mode) begin
            n_wheel = 1'b0;
        end else begin
            // saturating hold counter
            if (in_right) begin
                n_hold = (r_hold == HOLD_MAX) ? r_hold : r_hold + 1'b1;
            end else begin
                n_hold = '0;
            end
            hold_over = n_hold > {1'b0, r_hold_lim};

            // wheel toggle, press-on and hold-off
            if (!r_wheel && (r_lock == '0)) begin
                n_wheel = sw_edge || (n_hold != '0);
            end else if (r_wheel) begin
                n_wheel = !(sw_edge || hold_over);
                if (hold_over) begin
                    lock_mid = r_lockout;
                end
            end

            n_last_sw = in_sw;
            n_lock    = (lock_mid != '0) ? lock_mid - 1'b1 : lock_mid;

            // trigger pulse train
            if (n_wheel) begin
                if (in_left || (in_sw == SW_DOWN)) begin
                    fire_cnt = (r_fire == FIRE_MAX) ? r_fire : r_fire + 1'b1;
                end else begin
                    fire_cnt = '0;
                end
                if ((fire_cnt != '0) && (fire_cnt < r_fire_per)) begin
                    trig = 1'b1;
                end else if ((fire_cnt >= r_fire_per) &&
                             ({1'b0, fire_cnt} < ({1'b0, r_fire_per} + FIRE_GAP))) begin
                    fire_cnt = '0;
                end
                n_fire = fire_cnt;
            end
        end

        n_res.wheel_pwm  = n_wheel ? r_run_pwm : r_idle_pwm;
        n_res.laser_en   = n_wheel;
        n_res.trigger_on = trig;
        n_res.wheel_on   = n_wheel;
    end

    // state update on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel   <= 1'b0;
            r_last_sw <= '0;
            r_hold    <= '0;
            r_lock    <= '0;
            r_fire    <= '0;
        end else if (accept) begin
            r_wheel   <= n_wheel;
            r_last_sw <= n_last_sw;
            r_hold    <= n_hold;
            r_lock    <= n_lock;
            r_fire    <= n_fire;
        end
    end

    // output register with skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
                if (accept) begin
                    r_out <= n_res;
                end
            end
        end else if (accept) begin
            if (!r_out_valid) begin
                r_out       <= n_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

// ===== hdl/ses_checker.sv =====
`include "assert_macros.svh"

// port-level checks on the sequencer
module ses_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [ses_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import ses_pkg::*;

    t_result out_res;
    logic    out_stall;

    // result fields as seen on the master side
    assign out_res   = m_axis_tdata[$bits(t_result)-1:0];
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // laser always follows the wheel state
    `ASSERT_IMPLY(a_laser_follows_wheel, i_clk, i_rst_n, m_axis_tvalid, out_res.laser_en == out_res.wheel_on)

    // trigger only fires with the wheel running
    `ASSERT_IMPLY(a_trigger_needs_wheel, i_clk, i_rst_n, m_axis_tvalid && out_res.trigger_on, out_res.wheel_on)

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // no result right after reset
    `ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid && s_axis_tready)

    // an idle output side never refuses input
    `ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind shooter_enable_sequencer ses_checker u_ses_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ses_pkg::*;

    // one tick as packed on s_axis_tdata, lowest field last
    typedef struct packed {
        logic            left;
        logic            right;
        logic [SW_W-1:0] sw;
        logic [MODE_W-1:0] mode;
    } t_tick;

    localparam logic [SW_W-1:0]      SW_NONE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_LOCKOUT + 3'd1;
    localparam int                   PRINT_CAP       = 20;
    localparam int                   FIRE_BURST      = 20;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    // predicted register file
    logic [PWM_W-1:0]  idle_pwm  = RST_IDLE_PWM;
    logic [PWM_W-1:0]  run_pwm   = RST_RUN_PWM;
    logic [BYTE_W-1:0] fire_per  = RST_FIRE_PER;
    logic [BYTE_W-1:0] hold_lim  = RST_HOLD_LIM;
    logic [BYTE_W-1:0] lock_len  = RST_LOCKOUT;

    // predicted sequencer state
    logic              wheel_st  = 1'b0;
    logic [SW_W-1:0]   prev_sw   = SW_NONE;
    logic [HOLD_W-1:0] hold_cnt  = '0;
    logic [BYTE_W-1:0] lock_cnt  = '0;
    logic [BYTE_W-1:0] fire_cnt  = '0;

    t_tick   pending_ticks[$];
    t_result awaited_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int ticks_queued   = 0;
    int ticks_sent     = 0;
    int results_seen   = 0;
    int trigger_pulses = 0;
    int turn_ons       = 0;
    int mismatches     = 0;
    int reg_writes     = 0;
    int phase_count    = 0;
    logic last_wheel_seen = 1'b0;

    shooter_enable_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // one control tick of the sequencer, updates the predicted state
    function automatic t_result shooter_step(t_tick tk);
        t_result res;
        logic    flip;
        logic    trig;
        trig = 1'b0;
        if (tk.mode == MODE_PREPARE || tk.mode == MODE_STANDBY) begin
            wheel_st = 1'b0;
        end else begin
            flip = (tk.sw == SW_MID) && (prev_sw == SW_UP);
            if (tk.right) begin
                if (hold_cnt != HOLD_MAX) hold_cnt = hold_cnt + 1'b1;
            end else begin
                hold_cnt = '0;
            end
            if (!wheel_st && lock_cnt == 0) begin
                if (flip || hold_cnt != 0) wheel_st = 1'b1;
            end else if (wheel_st) begin
                if (flip) wheel_st = 1'b0;
                // hold-off: wheel off and lockout armed
                if (hold_cnt > HOLD_W'(hold_lim)) begin
                    wheel_st = 1'b0;
                    lock_cnt = lock_len;
                end
            end
            prev_sw = tk.sw;
            if (lock_cnt != 0) lock_cnt = lock_cnt - 1'b1;
            // trigger pulse train while the wheel runs
            if (wheel_st) begin
                if (tk.left || tk.sw == SW_DOWN) begin
                    if (fire_cnt != FIRE_MAX) fire_cnt = fire_cnt + 1'b1;
                end else begin
                    fire_cnt = '0;
                end
                if (fire_cnt != 0 && fire_cnt < fire_per) begin
                    trig = 1'b1;
                end else if (fire_cnt >= fire_per &&
                             int'(fire_cnt) < int'(fire_per) + int'(FIRE_GAP)) begin
                    fire_cnt = '0;
                end
            end
        end
        res.wheel_pwm  = wheel_st ? run_pwm : idle_pwm;
        res.laser_en   = wheel_st;
        res.trigger_on = trig;
        res.wheel_on   = wheel_st;
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatches < PRINT_CAP)
            $display("%0t: result %0d %s: got %0h, expected %0h",
                     $time, results_seen, what, got, want);
        mismatches++;
    endtask

    // tick driver: pops pending ticks, predicts each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_results.push_back(
                    shooter_step(t_tick'(s_axis_tdata[$bits(t_tick)-1:0])));
                ticks_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_TDATA_W'(pending_ticks.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: random backpressure, field compare
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_result)-1:0];
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected transaction", m_axis_tdata, 0);
            end else begin
                want = awaited_results.pop_front();
                if (got.wheel_pwm !== want.wheel_pwm)
                    report_mismatch("wheel_pwm", got.wheel_pwm, want.wheel_pwm);
                if (got.laser_en !== want.laser_en)
                    report_mismatch("laser_en", got.laser_en, want.laser_en);
                if (got.trigger_on !== want.trigger_on)
                    report_mismatch("trigger_on", got.trigger_on, want.trigger_on);
                if (got.wheel_on !== want.wheel_on)
                    report_mismatch("wheel_on", got.wheel_on, want.wheel_on);
                if (m_axis_tdata[OUT_TDATA_W-1:$bits(t_result)] !== '0)
                    report_mismatch("padding", m_axis_tdata[OUT_TDATA_W-1:$bits(t_result)], 0);
                if (want.trigger_on) trigger_pulses++;
                if (want.wheel_on && !last_wheel_seen) turn_ons++;
                last_wheel_seen = want.wheel_on;
            end
            results_seen++;
        end
    end

    task automatic push_tick(logic [MODE_W-1:0] mode, logic [SW_W-1:0] sw,
                             logic right, logic left);
        t_tick tk;
        tk.mode  = mode;
        tk.sw    = sw;
        tk.right = right;
        tk.left  = left;
        pending_ticks.push_back(tk);
        ticks_queued++;
    endtask

    function automatic logic [MODE_W-1:0] run_mode();
        return $urandom_range(1) ? MODE_REMOTE : MODE_KEYBRD;
    endfunction

    // wait until every queued tick has produced its result
    task automatic settle();
        while (pending_ticks.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_IDLE_PWM: idle_pwm = data;
            REG_RUN_PWM:  run_pwm  = data;
            REG_FIRE_PER: fire_per = data[BYTE_W-1:0];
            REG_HOLD_LIM: hold_lim = data[BYTE_W-1:0];
            REG_LOCKOUT:  lock_len = data[BYTE_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // byte registers get random junk in the upper data bits
    task automatic load_config(logic [PWM_W-1:0] idle, logic [PWM_W-1:0] run,
                               logic [BYTE_W-1:0] per, logic [BYTE_W-1:0] lim,
                               logic [BYTE_W-1:0] lock);
        write_reg(REG_IDLE_PWM, idle);
        write_reg(REG_RUN_PWM, run);
        write_reg(REG_FIRE_PER, {8'($urandom), per});
        write_reg(REG_HOLD_LIM, {8'($urandom), lim});
        write_reg(REG_LOCKOUT, {8'($urandom), lock});
    endtask

    // mostly well-formed operator sequences with random content, some noise
    task automatic queue_scenarios(int budget);
        int start;
        int len;
        int lim;
        int per;
        start = ticks_queued;
        while (ticks_queued - start < budget) begin
            lim = int'(hold_lim);
            per = int'(fire_per);
            case ($urandom_range(9))
                0, 1: begin
                    // switch flick from up to middle
                    repeat ($urandom_range(1, 3))
                        push_tick(run_mode(), SW_UP, 1'b0, 1'($urandom));
                    repeat ($urandom_range(1, 3)) push_tick(run_mode(), SW_MID, 1'b0, 1'b0);
                end
                2: begin
                    // short right press
                    repeat ($urandom_range(1, 4)) push_tick(run_mode(), SW_UP, 1'b1, 1'b0);
                    repeat ($urandom_range(1, 3)) push_tick(run_mode(), SW_UP, 1'b0, 1'b0);
                end
                3: begin
                    // right hold, past the limit when the limit is under 60
                    len = (lim < 60) ? lim + $urandom_range(1, 6) : $urandom_range(1, 60);
                    repeat (len) push_tick(run_mode(), SW_UP, 1'b1, 1'($urandom));
                    push_tick(run_mode(), SW_UP, 1'b0, 1'b0);
                end
                4, 5: begin
                    // fire request by left button or switch down
                    len = $urandom_range(1, (per > 30) ? 60 : 2 * per + 8);
                    repeat (len) begin
                        if ($urandom_range(19) == 0)
                            push_tick(run_mode(), SW_UP, 1'b0, 1'b0);
                        else if ($urandom_range(1))
                            push_tick(run_mode(), SW_DOWN, 1'b0, 1'($urandom));
                        else
                            push_tick(run_mode(), SW_UP, 1'b0, 1'b1);
                    end
                end
                6: begin
                    // quiet run ticks to let a lockout run out
                    repeat ($urandom_range(1, 30)) push_tick(run_mode(), SW_UP, 1'b0, 1'b0);
                end
                7: begin
                    // stop modes with anything on the controls
                    repeat ($urandom_range(1, 5))
                        push_tick($urandom_range(1) ? MODE_PREPARE : MODE_STANDBY,
                                  SW_W'($urandom), 1'($urandom), 1'($urandom));
                end
                8: begin
                    repeat ($urandom_range(1, 6))
                        push_tick(MODE_W'($urandom), SW_W'($urandom),
                                  1'($urandom), 1'($urandom));
                end
                default: begin
                    // flick while firing
                    repeat ($urandom_range(1, 4)) push_tick(run_mode(), SW_UP, 1'b0, 1'b1);
                    repeat ($urandom_range(1, 4)) push_tick(run_mode(), SW_MID, 1'b0, 1'b1);
                end
            endcase
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int budget);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queue_scenarios(budget);
        settle();
        phase_count++;
    endtask

    // stimulus sequencing and end of test
    initial begin
        int wait_cycles;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks under reset register values
        push_tick(MODE_PREPARE, SW_MID,  1'b1, 1'b1);
        push_tick(MODE_STANDBY, SW_DOWN, 1'b1, 1'b1);
        push_tick(MODE_REMOTE,  SW_NONE, 1'b0, 1'b0);
        push_tick(MODE_REMOTE,  SW_UP,   1'b0, 1'b0);
        push_tick(MODE_REMOTE,  SW_MID,  1'b0, 1'b0);
        push_tick(MODE_KEYBRD,  SW_DOWN, 1'b0, 1'b0);
        push_tick(MODE_KEYBRD,  SW_DOWN, 1'b0, 1'b0);
        push_tick(MODE_REMOTE,  SW_MID,  1'b0, 1'b1);
        push_tick(MODE_REMOTE,  SW_MID,  1'b0, 1'b0);
        push_tick(MODE_REMOTE,  SW_UP,   1'b0, 1'b0);
        push_tick(MODE_REMOTE,  SW_MID,  1'b0, 1'b0);
        push_tick(MODE_KEYBRD,  SW_MID,  1'b1, 1'b0);
        push_tick(MODE_KEYBRD,  SW_MID,  1'b0, 1'b1);
        push_tick(MODE_PREPARE, SW_UP,   1'b0, 1'b1);
        push_tick(MODE_KEYBRD,  SW_UP,   1'b1, 1'b1);
        push_tick(MODE_STANDBY, SW_MID,  1'b1, 1'b0);
        push_tick(MODE_REMOTE,  SW_MID,  1'b1, 1'b1);
        push_tick(MODE_REMOTE,  SW_NONE, 1'b0, 1'b0);
        settle();
        phase_count++;

        // lowest legal settings
        load_config(16'h0000, 16'hFFFF, 8'd2, 8'd1, 8'd1);
        run_phase(56, 0, 35);

        // highest legal settings
        load_config(16'hFFFF, 16'h0000, 8'd250, 8'd255, 8'd255);
        run_phase(0, 56, 35);

        // zero period, zero limit, zero lockout
        load_config(PWM_W'($urandom), PWM_W'($urandom), 8'd0, 8'd0, 8'd0);
        run_phase(37, 37, 25);

        // period of one, plus writes to unused indexes
        load_config(PWM_W'($urandom), PWM_W'($urandom), 8'd1,
                    8'($urandom_range(1, 20)), 8'($urandom_range(1, 20)));
        for (int idx = REG_SPARE_FIRST; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        run_phase(0, 0, 25);

        // fire and hold counter saturation: start a burst, drop the period,
        // then hold both buttons until the hold count tops out
        load_config(PWM_W'($urandom), PWM_W'($urandom), 8'd250, 8'd255, 8'd10);
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        repeat (int'(lock_cnt) + 1) push_tick(MODE_REMOTE, SW_UP, 1'b0, 1'b0);
        push_tick(MODE_REMOTE, SW_UP, 1'b1, 1'b0);
        push_tick(MODE_REMOTE, SW_UP, 1'b0, 1'b0);
        repeat (FIRE_BURST) push_tick(run_mode(), SW_UP, 1'b0, 1'b1);
        settle();
        write_reg(REG_FIRE_PER, 16'd2);
        repeat (int'(HOLD_MAX) + 8) push_tick(run_mode(), SW_UP, 1'b1, 1'b1);
        // let the lockout run out, turn on and release the fire request
        repeat (12) push_tick(run_mode(), SW_UP, 1'b0, 1'b0);
        push_tick(run_mode(), SW_UP, 1'b1, 1'b0);
        push_tick(run_mode(), SW_UP, 1'b0, 1'b0);
        repeat (5) push_tick(run_mode(), SW_DOWN, 1'b0, 1'b0);
        settle();
        phase_count++;

        // random settings, short periods and lockouts so events repeat
        for (int ph = 0; ph < 4; ph++) begin
            load_config(PWM_W'($urandom), PWM_W'($urandom), 8'($urandom_range(2, 12)),
                        8'($urandom_range(1, 30)), 8'($urandom_range(1, 40)));
            case (ph)
                0: run_phase(0, 0, 25);
                1: run_phase(56, 0, 25);
                2: run_phase(0, 56, 25);
                default: run_phase(37, 37, 25);
            endcase
        end

        // drain with a bound, then a few spare cycles
        wait_cycles = 0;
        while (awaited_results.size() != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (5) @(posedge i_clk);
        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", awaited_results.size(), 0);

        $display("covered %0d ticks over %0d phases with %0d register writes",
                 ticks_sent, phase_count, reg_writes);
        $display("checked %0d results: %0d trigger ticks, %0d wheel turn-ons, %0d mismatches",
                 results_seen, trigger_pulses, turn_ons, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("timeout after %0d ticks sent, %0d results", ticks_sent, results_seen);
        $display("FAILURE");
        $finish;
    end

endmodule
